/* rtl/core/pse_pkg.sv */
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants of the postfix stack evaluator
// token codes, error codes, item structs and the letter-to-index mapping
// ----------------------------------------------------------------------------
`default_nettype none
package pse_pkg;
	localparam int unsigned STACK_DEPTH_DEF   = 16;
	localparam int unsigned NUM_VARIABLES_DEF = 52;
	localparam int unsigned VAR_IDX_W         = 6;

	localparam logic [7:0] CH_ADD = 8'h2B;
	localparam logic [7:0] CH_SUB = 8'h2D;
	localparam logic [7:0] CH_MUL = 8'h2A;
	localparam logic [7:0] CH_DIV = 8'h2F;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
	localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
	localparam logic [2:0] ERR_DIVZERO   = 3'd4;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_TOKEN = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [7:0]         token_char;
		logic signed [31:0] var_value;
		logic               expr_end;
	} pse_in_t;

	typedef struct packed {
		logic signed [31:0] final_value;
		logic [2:0]         error_code;
	} pse_out_t;

	// letter to table index; is_letter low for any other character
	typedef struct packed {
		logic                 is_letter;
		logic [VAR_IDX_W-1:0] idx;
	} letter_t;

	function automatic letter_t letter_index(input logic [7:0] c);
		letter_t r;
		r.is_letter = 1'b0;
		r.idx       = '0;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r.is_letter = 1'b1;
			r.idx       = VAR_IDX_W'(c - 8'h61);
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			r.is_letter = 1'b1;
			r.idx       = VAR_IDX_W'(c - 8'h41 + 8'd26);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

/* rtl/core/postfix_stack_evaluator_top.sv */
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_top: postfix expression evaluator
// one ascii token per item, 32-bit operand stack, letter-keyed variable table
// ----------------------------------------------------------------------------
// item steps: a write is taken in idle; a token goes READ, READ2, EXEC, FINISH;
// / also waits in DIVWAIT after EXEC until the radix-2 divider is done
// the last token of an expression then goes to EMIT to load the result register
// one token at a time: ready is low from acceptance until the token has retired
// a result item waits in an output register while the next items are taken
// reset clears count, sticky error, valid bits and control, not stack or table contents
`default_nettype none
module postfix_stack_evaluator_top #(
	parameter int unsigned STACK_DEPTH   = pse_pkg::STACK_DEPTH_DEF,
	parameter int unsigned NUM_VARIABLES = pse_pkg::NUM_VARIABLES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire pse_pkg::pse_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output pse_pkg::pse_out_t     out_data
);
	import pse_pkg::*;

	localparam int unsigned SP_W  = $clog2(STACK_DEPTH);
	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned VI_W  = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_READ2, ST_EXEC, ST_DIVWAIT, ST_FINISH, ST_EMIT
	} state_t;

	state_t state_q;

	// storage
	logic [31:0] stack_mem [STACK_DEPTH];
	logic [31:0] var_mem   [NUM_VARIABLES];
	logic [NUM_VARIABLES-1:0] var_valid_q;
	logic [CNT_W-1:0] count_q;
	logic [2:0]       err_q;

	// item registers
	pse_in_t     item_q;
	letter_t     let_q;
	logic [31:0] rd_q, rhs_q, lhs_q;
	logic        out_pend_q;
	pse_out_t    out_q;

	// letter decode of the offered item
	letter_t     in_let;
	logic        in_let_ok;
	assign in_let    = letter_index(in_data.token_char);
	assign in_let_ok = in_let.is_letter && (32'(in_let.idx) < NUM_VARIABLES);

	// divider for / tokens
	logic        div_start, div_done;
	logic [31:0] div_quo;

	// stack pointers for operand reads: top and one below
	logic [SP_W-1:0] top_idx, sub_idx, push_idx;
	assign top_idx  = SP_W'(count_q - CNT_W'(1));
	assign sub_idx  = SP_W'(count_q - CNT_W'(2));
	assign push_idx = SP_W'(count_q);

	logic is_op, letter_ok;
	assign is_op = (item_q.token_char == CH_ADD) || (item_q.token_char == CH_SUB) ||
		(item_q.token_char == CH_MUL) || (item_q.token_char == CH_DIV);
	assign letter_ok = let_q.is_letter && (32'(let_q.idx) < NUM_VARIABLES) &&
		var_valid_q[VI_W'(let_q.idx)];

	// accept in idle; a new result waits in emit until the out register frees
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_pend_q;
	assign out_data  = out_q;
	assign div_start = (state_q == ST_EXEC) && (item_q.token_char == CH_DIV) &&
		(rhs_q != 32'd0);

	pse_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lhs_q),
		.divisor  (rhs_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// variable table write, one port
	always_ff @(posedge clk) begin
		if (in_valid && in_ready && in_data.req_type == REQ_WRITE) begin
			if (in_let_ok)
				var_mem[VI_W'(in_let.idx)] <= in_data.var_value;
		end
	end

	// variable and stack reads, registered; top of stack read again for the result
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q  <= var_mem[VI_W'(let_q.idx)];
			rhs_q <= stack_mem[top_idx];
		end
		if (state_q == ST_READ2)
			lhs_q <= stack_mem[sub_idx];
		if (state_q == ST_FINISH)
			rd_q <= stack_mem[top_idx];
	end

	// stack write port: push or result replace
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && err_q == ERR_NONE) begin
			if (let_q.is_letter && letter_ok && count_q < CNT_W'(STACK_DEPTH))
				stack_mem[push_idx] <= rd_q;
			else if (!let_q.is_letter && is_op && count_q >= CNT_W'(2)) begin
				if (item_q.token_char == CH_ADD)
					stack_mem[sub_idx] <= lhs_q + rhs_q;
				else if (item_q.token_char == CH_SUB)
					stack_mem[sub_idx] <= lhs_q - rhs_q;
				else if (item_q.token_char == CH_MUL)
					stack_mem[sub_idx] <= 32'(lhs_q * rhs_q);
			end
		end else if (state_q == ST_DIVWAIT && div_done)
			stack_mem[sub_idx] <= div_quo;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			var_valid_q <= '0;
			count_q     <= '0;
			err_q       <= ERR_NONE;
			out_pend_q  <= 1'b0;
		end else begin
			if (out_pend_q && out_ready)
				out_pend_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						item_q <= in_data;
						let_q  <= in_let;
						if (in_data.req_type == REQ_WRITE) begin
							if (in_let_ok)
								var_valid_q[VI_W'(in_let.idx)] <= 1'b1;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ:  state_q <= ST_READ2;
				ST_READ2: state_q <= ST_EXEC;
				ST_EXEC: begin
					state_q <= ST_FINISH;
					if (err_q == ERR_NONE) begin
						if (let_q.is_letter) begin
							if (!letter_ok)
								err_q <= ERR_UNKNOWN;
							else if (count_q >= CNT_W'(STACK_DEPTH))
								err_q <= ERR_OVERFLOW;
							else
								count_q <= count_q + CNT_W'(1);
						end else if (is_op) begin
							if (count_q < CNT_W'(2))
								err_q <= ERR_UNDERFLOW;
							else if (item_q.token_char == CH_DIV) begin
								if (rhs_q == 32'd0)
									err_q <= ERR_DIVZERO;
								else
									state_q <= ST_DIVWAIT;
							end else
								count_q <= count_q - CNT_W'(1);
						end
					end
				end
				ST_DIVWAIT: begin
					if (div_done) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// top of stack is read here for the result
					state_q <= item_q.expr_end ? ST_EMIT : ST_IDLE;
					if (item_q.expr_end && err_q == ERR_NONE && count_q == '0)
						err_q <= ERR_UNDERFLOW;
				end
				ST_EMIT: begin
					// hold until the previous result item has left
					if (!out_pend_q || out_ready) begin
						out_q.final_value <= (err_q == ERR_NONE) ? rd_q : 32'd0;
						out_q.error_code  <= err_q;
						out_pend_q        <= 1'b1;
						count_q           <= '0;
						err_q             <= ERR_NONE;
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/core/pse_divider.sv */
// ----------------------------------------------------------------------------
// pse_divider: iterative signed divider
// restoring division one quotient bit per cycle, truncation toward zero
// ----------------------------------------------------------------------------
`default_nettype none
module pse_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);
	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0]  cnt_q;
	logic        busy_q, neg_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	assign shifted = {rem_q[30:0], quo_q[31]};
	assign trial   = {1'b0, shifted} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? 32'd0 - dividend : dividend;
			den_q <= divisor[31] ? 32'd0 - divisor : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? 32'd0 - quo_q : quo_q;
endmodule
`default_nettype wire

/* rtl/core/pse_checker.sv */
// ----------------------------------------------------------------------------
// pse_checker: port-level checks of the postfix stack evaluator
// watches the result handshake and the result codes, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
module pse_port_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire pse_pkg::pse_out_t out_data
);
	import pse_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.error_code <= ERR_DIVZERO)
		else $error("error code out of range");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code != ERR_NONE |-> out_data.final_value == 32'sd0)
		else $error("non-zero value with error");
endmodule

bind postfix_stack_evaluator_top pse_port_checker u_pse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

/* dv/pse_checker.sv */
// ----------------------------------------------------------------------------
// pse_checker: result predictor and scoreboard for the postfix evaluator
// watches both channels, evaluates each accepted item and compares results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pse_checker (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_ready,
	input  wire pse_pkg::pse_in_t in_data,
	input  wire logic             out_valid,
	input  wire logic             out_ready,
	input  wire pse_pkg::pse_out_t out_data,
	output int                    fail_count,
	output int                    results_pending
);
	import pse_pkg::*;

	localparam int DEPTH = STACK_DEPTH_DEF;

	logic [31:0] eval_stack [DEPTH];
	int          eval_depth;
	logic [31:0] var_store [NUM_VARIABLES_DEF];
	logic        var_known [NUM_VARIABLES_DEF];
	logic [2:0]  expr_fault;
	pse_out_t    expected_results [$];

	assign results_pending = expected_results.size();

	function automatic logic [31:0] quot_trunc(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q  = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	task automatic apply_token(input logic [7:0] c);
		letter_t     li;
		logic [31:0] rhs, lhs, r;
		li = letter_index(c);
		if (li.is_letter) begin
			if (li.idx >= NUM_VARIABLES_DEF || !var_known[li.idx])
				expr_fault = ERR_UNKNOWN;
			else if (eval_depth >= DEPTH)
				expr_fault = ERR_OVERFLOW;
			else begin
				eval_stack[eval_depth] = var_store[li.idx];
				eval_depth++;
			end
			return;
		end
		if (c != CH_ADD && c != CH_SUB && c != CH_MUL && c != CH_DIV)
			return;
		if (eval_depth < 2) begin
			expr_fault = ERR_UNDERFLOW;
			return;
		end
		rhs = eval_stack[eval_depth-1];
		lhs = eval_stack[eval_depth-2];
		case (c)
			CH_ADD: r = lhs + rhs;
			CH_SUB: r = lhs - rhs;
			CH_MUL: r = lhs * rhs;
			default: begin
				if (rhs == 0) begin
					expr_fault = ERR_DIVZERO;
					return;
				end
				r = quot_trunc(lhs, rhs);
			end
		endcase
		eval_depth--;
		eval_stack[eval_depth-1] = r;
	endtask

	task automatic predict_item(input pse_in_t it);
		letter_t  li;
		pse_out_t res;
		if (it.req_type == REQ_WRITE) begin
			li = letter_index(it.token_char);
			if (li.is_letter && li.idx < NUM_VARIABLES_DEF) begin
				var_store[li.idx] = it.var_value;
				var_known[li.idx] = 1'b1;
			end
			return;
		end
		if (expr_fault == ERR_NONE)
			apply_token(it.token_char);
		if (!it.expr_end)
			return;
		if (expr_fault == ERR_NONE && eval_depth == 0)
			expr_fault = ERR_UNDERFLOW;
		res.final_value = (expr_fault == ERR_NONE) ? eval_stack[eval_depth-1] : '0;
		res.error_code  = expr_fault;
		expected_results.push_back(res);
		eval_depth = 0;
		expr_fault = ERR_NONE;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pse_out_t want;
		if (!arst_n) begin
			eval_depth = 0;
			expr_fault = ERR_NONE;
			fail_count = 0;
			for (int i = 0; i < NUM_VARIABLES_DEF; i++)
				var_known[i] = 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_item(in_data);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result value=%0d err=%0d", $time,
						out_data.final_value, out_data.error_code);
				end else begin
					want = expected_results.pop_front();
					if (want.final_value !== out_data.final_value) begin
						fail_count++;
						$display("%0t: final_value expected %0d actual %0d", $time,
							want.final_value, out_data.final_value);
					end
					if (want.error_code !== out_data.error_code) begin
						fail_count++;
						$display("%0t: error_code expected %0d actual %0d", $time,
							want.error_code, out_data.error_code);
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

/* dv/tb_postfix_stack_evaluator_top.sv */
// ----------------------------------------------------------------------------
// tb_postfix_stack_evaluator_top: testbench of the postfix evaluator
// directed expressions then random ones under several idling phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_postfix_stack_evaluator_top;
	import pse_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 400;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	pse_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	pse_out_t out_data;
	int       fail_count;
	int       results_pending;

	// idling percentages per phase, changed by the stimulus process
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	logic     hold_off = 1'b0;
	int       idle_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	postfix_stack_evaluator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	pse_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.fail_count(fail_count), .results_pending(results_pending)
	);

	// receiver side: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles with no accepted item on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// offer one item, with random idle cycles before it, and wait for acceptance
	// valid stays high after acceptance until the next idle or release
	task automatic send_item(input logic rt, input logic [7:0] c,
		input logic [31:0] v, input logic e);
		pse_in_t it;
		it.req_type = rt;
		it.token_char = c;
		it.var_value = v;
		it.expr_end = e;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// drop valid after the last item of a stretch
	task automatic release_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_var(input logic [7:0] c, input logic [31:0] v);
		send_item(REQ_WRITE, c, v, 1'b0);
	endtask

	function automatic logic [7:0] any_letter();
		int k;
		k = $urandom_range(51);
		return (k < 26) ? 8'(8'h61 + k) : 8'(8'h41 + k - 26);
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'd0;
			4: return $urandom_range(20) - 10;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(3))
			0: return CH_ADD;
			1: return CH_SUB;
			2: return CH_MUL;
			default: return CH_DIV;
		endcase
	endfunction

	// mostly a well-formed expression over random variables; sometimes broken
	task automatic random_expression(output int n_items);
		int depth, len, target;
		logic [7:0] c;
		letter_t lc;
		depth = 0;
		n_items = 0;
		target = ($urandom_range(9) == 0) ? 18 : $urandom_range(1, 6);
		len = 0;
		while (len < 2 * target) begin
			if ($urandom_range(15) == 0)
				c = 8'($urandom);  // noise, possibly unknown or bad token
			else if (depth >= 2 && ($urandom_range(1) == 0 || depth >= target))
				c = rand_op();
			else
				c = any_letter();
			lc = letter_index(c);
			if (lc.is_letter)
				depth++;
			else if (c == CH_ADD || c == CH_SUB || c == CH_MUL || c == CH_DIV)
				depth = (depth > 0) ? depth - 1 : 0;
			send_item(REQ_TOKEN, c, $urandom, 1'b0);
			n_items++;
			len++;
			if (depth == 1 && len >= target && $urandom_range(2) == 0)
				break;
		end
		send_item(REQ_TOKEN, ($urandom_range(3) == 0) ? rand_op() : 8'h20,
			$urandom, 1'b1);
		n_items++;
	endtask

	task automatic wait_drained();
		while (results_pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int n, sent, drain;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unknown variable before any write, empty end, underflow
		send_item(REQ_TOKEN, 8'h61, 32'd0, 1'b1);
		send_item(REQ_TOKEN, 8'h20, 32'd0, 1'b1);
		send_item(REQ_TOKEN, CH_ADD, 32'd0, 1'b1);
		write_var(8'h61, 32'h8000_0000);
		write_var(8'h62, 32'hffff_ffff);
		write_var(8'h5A, 32'h7fff_ffff);
		write_var(8'h7A, 32'd0);
		write_var(8'h31, 32'd5);                   // non-letter write ignored
		send_item(REQ_WRITE, 8'h41, 32'd3, 1'b1);  // write with end: no result
		// most negative divided by minus one
		send_item(REQ_TOKEN, 8'h61, 32'd0, 1'b0);
		send_item(REQ_TOKEN, 8'h62, 32'd0, 1'b0);
		send_item(REQ_TOKEN, CH_DIV, 32'd0, 1'b1);
		// divide by zero, then an ignored token after the fault
		send_item(REQ_TOKEN, 8'h5A, 32'd0, 1'b0);
		send_item(REQ_TOKEN, 8'h7A, 32'd0, 1'b0);
		send_item(REQ_TOKEN, CH_DIV, 32'd0, 1'b0);
		send_item(REQ_TOKEN, CH_MUL, 32'd0, 1'b1);
		// add, subtract, multiply
		send_item(REQ_TOKEN, 8'h5A, 32'd0, 1'b0);
		send_item(REQ_TOKEN, 8'h41, 32'd0, 1'b0);
		send_item(REQ_TOKEN, CH_ADD, 32'd0, 1'b0);
		send_item(REQ_TOKEN, 8'h62, 32'd0, 1'b0);
		send_item(REQ_TOKEN, CH_SUB, 32'd0, 1'b0);
		send_item(REQ_TOKEN, 8'h5A, 32'd0, 1'b0);
		send_item(REQ_TOKEN, CH_MUL, 32'd0, 1'b1);
		// overflow: seventeen pushes
		for (int i = 0; i < 17; i++)
			send_item(REQ_TOKEN, 8'h62, 32'd0, i == 16);

		// fill the table so most letters are known; only Y stays unknown
		for (int i = 0; i < 50; i++)
			write_var((i < 26) ? 8'(8'h61 + i) : 8'(8'h41 + i - 26), rand_value());
		release_input();
		wait_drained();

		// long receiver hold-off while the sender keeps offering items
		hold_off <= 1'b1;
		fork
			begin
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
			for (int i = 0; i < 6; i++)
				random_expression(n);
		join

		sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			while (sent < (phase + 1) * 400) begin
				if ($urandom_range(9) == 0) begin
					// occasional write, any character and value
					send_item(REQ_WRITE,
						($urandom_range(1) == 0) ? any_letter() : 8'($urandom),
						rand_value(), 1'($urandom));
					sent++;
				end else begin
					random_expression(n);
					sent += n;
				end
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		release_input();

		wait_drained();
		drain = 0;
		while (drain < 100) begin
			@(posedge clk);
			drain++;
		end
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
rtl/core/pse_pkg.sv
rtl/core/pse_divider.sv
rtl/core/postfix_stack_evaluator_top.sv
rtl/core/pse_checker.sv
dv/pse_checker.sv
dv/tb_postfix_stack_evaluator_top.sv
